@@ hdl/pfor_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfor_pkg;

  localparam int WIDTH_MAX = 32;
  localparam int SLOT_BITS = 6;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TRUNC     = 3'd1,
    STAT_BAD_WIDTH = 3'd2,
    STAT_W32_EXC   = 3'd3,
    STAT_BAD_POS   = 3'd4,
    STAT_BAD_VINT  = 3'd5,
    STAT_HIGH_WIDE = 3'd6
  } status_t;

  typedef enum logic [6:0] {
    ST_HEADER = 7'b0000001,
    ST_COUNT  = 7'b0000010,
    ST_POS    = 7'b0000100,
    ST_VARINT = 7'b0001000,
    ST_STREAM = 7'b0010000,
    ST_ZEMIT  = 7'b0100000,
    ST_DROP   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [6:0] value_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  value_index;
    logic        value_valid;
    logic        block_done;
    logic [2:0]  status;
    logic [10:0] bytes_used;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/pfor_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfor_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/pfor_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue; push is ignored while full, pop while empty.
module pfor_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic      [W-1:0] rdata
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pfor_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame parser and value emitter. Consumes at most one byte and gives at
// most one result per cycle; the exception table sits in a RAM.
module pfor_back #(
  parameter int MAX_VALUES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_avail,
  input  wire pfor_pkg::in_item_t in_item,
  output logic                   in_take,
  input  wire logic              res_full,
  output logic                   res_push,
  output pfor_pkg::res_t         res
);

  localparam logic [8:0] MAXV = 9'(MAX_VALUES);

  pfor_pkg::phase_t state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  width_r, width_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [7:0]  exc_tot_r, exc_tot_nxt;
  logic [7:0]  exc_seen_r, exc_seen_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] vacc_r, vacc_nxt;
  logic [2:0]  vb_r, vb_nxt;
  logic [63:0] present_r, present_nxt;
  logic [39:0] acc_r, acc_nxt;
  logic [5:0]  bc_r, bc_nxt;
  logic [6:0]  vals_r, vals_nxt;
  logic [10:0] bytes_r, bytes_nxt;
  logic [5:0]  rtag_r;
  logic        rok_r;

  logic        we;
  logic [31:0] wdata;
  logic [5:0]  raddr;
  logic [31:0] rdata;

  logic [7:0]  b;
  logic        fend;
  logic [6:0]  low7;
  logic [31:0] vpart, vacc2, lim, mask, low;
  logic [10:0] bytes_inc;

  pfor_ram #(.W(32), .D(64)) u_high (
    .clk  (clk),
    .we   (we),
    .waddr(pos_r),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign b         = in_item.frame_byte;
  assign fend      = in_item.frame_end;
  assign low7      = b[6:0];
  assign bytes_inc = bytes_r + 11'd1;
  assign lim       = (width_r >= 6'd32) ? 32'd0 : (32'hFFFF_FFFF >> width_r);
  assign mask      = (width_r >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << width_r) - 32'd1);
  assign low       = acc_r[31:0] & mask;

  always_comb begin
    case (vb_r)
      3'd0:    vpart = {25'd0, low7};
      3'd1:    vpart = {18'd0, low7, 7'd0};
      3'd2:    vpart = {11'd0, low7, 14'd0};
      3'd3:    vpart = {4'd0, low7, 21'd0};
      default: vpart = {low7[3:0], 28'd0};
    endcase
    vacc2 = vacc_r | vpart;
  end

  always_comb begin
    case (state_r)
      pfor_pkg::ST_POS:    raddr = b[5:0];
      pfor_pkg::ST_VARINT: raddr = pos_r;
      default:             raddr = vals_r[5:0];
    endcase
  end

  always_comb begin
    logic        hit;
    logic        done;
    logic [31:0] hi;
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    width_nxt    = width_r;
    count_nxt    = count_r;
    exc_tot_nxt  = exc_tot_r;
    exc_seen_nxt = exc_seen_r;
    pos_nxt      = pos_r;
    vacc_nxt     = vacc_r;
    vb_nxt       = vb_r;
    present_nxt  = present_r;
    acc_nxt      = acc_r;
    bc_nxt       = bc_r;
    vals_nxt     = vals_r;
    bytes_nxt    = bytes_r;
    in_take      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    res.block_done = 1'b1;
    we           = 1'b0;
    wdata        = present_r[pos_r] ? (rdata | vacc2) : vacc2;
    hit          = 1'b0;
    done         = 1'b0;
    hi           = '0;

    if (!res_full) begin
      case (state_r)
        pfor_pkg::ST_HEADER: begin
          if (in_avail) begin
            in_take      = 1'b1;
            bytes_nxt    = 11'd1;
            vals_nxt     = '0;
            exc_seen_nxt = '0;
            present_nxt  = '0;
            count_nxt    = in_item.value_count;
            width_nxt    = b[5:0];
            if (fend) begin
              res_push = 1'b1; res.status = pfor_pkg::STAT_TRUNC;
            end else if ({2'b0, in_item.value_count} > MAXV) begin
              res_push = 1'b1; res.status = pfor_pkg::STAT_BAD_POS;
            end else if (b > 8'd32) begin
              res_push = 1'b1; res.status = pfor_pkg::STAT_BAD_WIDTH;
            end else begin
              state_nxt = pfor_pkg::ST_COUNT;
            end
            // A bad header drops the rest of the frame.
            if (res_push && !fend) begin
              state_nxt = pfor_pkg::ST_DROP;
            end
          end
        end
        pfor_pkg::ST_COUNT, pfor_pkg::ST_POS, pfor_pkg::ST_VARINT: begin
          hit = rok_r && (rtag_r == pos_r);
          if (pend_r) begin
            res_push = 1'b1; res.status = pfor_pkg::STAT_TRUNC;
          end else if (in_avail && (state_r != pfor_pkg::ST_VARINT || hit)) begin
            in_take   = 1'b1;
            bytes_nxt = bytes_inc;
            pend_nxt  = fend;
            if (state_r == pfor_pkg::ST_COUNT) begin
              exc_tot_nxt = b;
              if (width_r == 6'd32 && b != 8'd0) begin
                res_push = 1'b1; res.status = pfor_pkg::STAT_W32_EXC;
              end else if (b == 8'd0) begin
                state_nxt = pfor_pkg::ST_STREAM;
              end else begin
                state_nxt = pfor_pkg::ST_POS;
              end
            end else if (state_r == pfor_pkg::ST_POS) begin
              if ({1'b0, b[6:0]} >= {1'b0, count_r} || b[7]) begin
                res_push = 1'b1; res.status = pfor_pkg::STAT_BAD_POS;
              end else begin
                pos_nxt   = b[5:0];
                vacc_nxt  = '0;
                vb_nxt    = '0;
                state_nxt = pfor_pkg::ST_VARINT;
              end
            end else begin
              if (vb_r == 3'd4 && low7 > 7'h0F) begin
                res_push = 1'b1; res.status = pfor_pkg::STAT_BAD_VINT;
              end else if (!b[7]) begin
                if (vacc2 > lim) begin
                  res_push = 1'b1; res.status = pfor_pkg::STAT_HIGH_WIDE;
                end else begin
                  we                   = 1'b1;
                  present_nxt[pos_r]   = 1'b1;
                  exc_seen_nxt         = exc_seen_r + 8'd1;
                  state_nxt = (exc_seen_nxt >= exc_tot_r) ? pfor_pkg::ST_STREAM
                                                          : pfor_pkg::ST_POS;
                end
              end else begin
                vacc_nxt = vacc2;
                vb_nxt   = vb_r + 3'd1;
                if (vb_nxt >= 3'd5) begin
                  res_push = 1'b1; res.status = pfor_pkg::STAT_BAD_VINT;
                end
              end
            end
            // Entering the value stream after a zero exception count or the last exception.
            if (!res_push && state_nxt == pfor_pkg::ST_STREAM) begin
              acc_nxt  = '0;
              bc_nxt   = '0;
              vals_nxt = '0;
              if (count_r == 7'd0) begin
                res_push       = 1'b1;
                res.status     = pfor_pkg::STAT_OK;
                res.bytes_used = bytes_nxt;
                state_nxt      = fend ? pfor_pkg::ST_HEADER : pfor_pkg::ST_DROP;
                pend_nxt       = 1'b0;
              end else if (width_r == 6'd0) begin
                state_nxt = pfor_pkg::ST_ZEMIT;
              end
            end
          end
          if (res_push && res.status != pfor_pkg::STAT_OK) begin
            state_nxt = (pend_r || fend) ? pfor_pkg::ST_HEADER : pfor_pkg::ST_DROP;
            pend_nxt  = 1'b0;
          end
        end
        pfor_pkg::ST_STREAM, pfor_pkg::ST_ZEMIT: begin
          hit = rok_r && (rtag_r == vals_r[5:0]);
          if (state_r == pfor_pkg::ST_ZEMIT || bc_r >= width_r) begin
            if (hit) begin
              hi = (present_r[vals_r[5:0]] && width_r < 6'd32) ? (rdata << width_r) : '0;
              done            = ({1'b0, vals_r} + 8'd1) >= {1'b0, count_r};
              res_push        = 1'b1;
              res.value       = ((state_r == pfor_pkg::ST_ZEMIT) ? 32'd0 : low) | hi;
              res.value_index = vals_r[5:0];
              res.value_valid = 1'b1;
              res.block_done  = done;
              res.status      = pfor_pkg::STAT_OK;
              res.bytes_used  = done ? bytes_r : 11'd0;
              vals_nxt        = vals_r + 7'd1;
              if (state_r == pfor_pkg::ST_STREAM) begin
                acc_nxt = acc_r >> width_r;
                bc_nxt  = bc_r - width_r;
              end
              if (done) begin
                state_nxt = pend_r ? pfor_pkg::ST_HEADER : pfor_pkg::ST_DROP;
                pend_nxt  = 1'b0;
              end
            end
          end else if (pend_r) begin
            res_push   = 1'b1;
            res.status = pfor_pkg::STAT_TRUNC;
            state_nxt  = pfor_pkg::ST_HEADER;
            pend_nxt   = 1'b0;
          end else if (in_avail) begin
            in_take   = 1'b1;
            bytes_nxt = bytes_inc;
            acc_nxt   = acc_r | (40'(b) << bc_r);
            bc_nxt    = bc_r + 6'd8;
            pend_nxt  = fend;
          end
        end
        pfor_pkg::ST_DROP: begin
          if (in_avail) begin
            in_take   = 1'b1;
            bytes_nxt = bytes_inc;
            if (fend) begin
              state_nxt = pfor_pkg::ST_HEADER;
            end
          end
        end
        default: begin
          state_nxt = pfor_pkg::ST_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pfor_pkg::ST_HEADER;
      pend_r     <= 1'b0;
      present_r  <= '0;
      rok_r      <= 1'b0;
      vals_r     <= '0;
      bytes_r    <= '0;
      exc_seen_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_r     <= pend_nxt;
      present_r  <= present_nxt;
      rok_r      <= !we;
      vals_r     <= vals_nxt;
      bytes_r    <= bytes_nxt;
      exc_seen_r <= exc_seen_nxt;
    end
    rtag_r    <= raddr;
    width_r   <= width_nxt;
    count_r   <= count_nxt;
    exc_tot_r <= exc_tot_nxt;
    pos_r     <= pos_nxt;
    vacc_r    <= vacc_nxt;
    vb_r      <= vb_nxt;
    acc_r     <= acc_nxt;
    bc_r      <= bc_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/pfor_block_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// in_*      | input     | in_push / in_full  | frame_byte, frame_end, value_count
// out_*     | output    | out_pop / out_empty| value, value_index, value_valid,
//           |           |                    | block_done, status, bytes_used
//
// Header, count and exception bytes are parsed as they arrive. A stream
// byte is taken into the bit accumulator; each value it completes waits
// for the registered read of the exception table RAM (one read port).
// Entering the stream right after an exception is written waits for a
// fresh read of the table.
// The input and result sides each have a two-entry queue, so a transfer on
// either side proceeds while the other stalls.
// Reset is synchronous and active low; it returns the parser to header wait
// and empties both queues. No clearing pass is needed.
module pfor_block_decoder_top #(
  parameter int MAX_VALUES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_end,
  input  wire logic [6:0]  in_value_count,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic      [31:0] out_value,
  output logic      [5:0]  out_value_index,
  output logic             out_value_valid,
  output logic             out_block_done,
  output logic      [2:0]  out_status,
  output logic      [10:0] out_bytes_used
);

  pfor_pkg::in_item_t in_w, item;
  pfor_pkg::res_t     res, res_q;
  logic               in_empty, take, res_push, res_full;

  // The front queue holds incoming bytes so a transfer completes even while
  // the parser is busy emitting values.
  assign in_w.frame_byte  = in_frame_byte;
  assign in_w.frame_end   = in_frame_end;
  assign in_w.value_count = in_value_count;

  pfor_fifo #(.W($bits(pfor_pkg::in_item_t))) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata(in_w),
    .full (in_full),
    .pop  (take),
    .empty(in_empty),
    .rdata(item)
  );

  // The back end parses the header and exceptions, and unpacks the stream.
  pfor_back #(.MAX_VALUES(MAX_VALUES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_avail(!in_empty),
    .in_item (item),
    .in_take (take),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  // Results wait here until the consumer pops them.
  pfor_fifo #(.W($bits(pfor_pkg::res_t))) u_out (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (out_pop),
    .empty(out_empty),
    .rdata(res_q)
  );

  assign out_value       = res_q.value;
  assign out_value_index = res_q.value_index;
  assign out_value_valid = res_q.value_valid;
  assign out_block_done  = res_q.block_done;
  assign out_status      = res_q.status;
  assign out_bytes_used  = res_q.bytes_used;

endmodule

`default_nettype wire

@@ hdl/pfor_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfor_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic [31:0] out_value,
  input wire logic [5:0]  out_value_index,
  input wire logic        out_value_valid,
  input wire logic        out_block_done,
  input wire logic [2:0]  out_status,
  input wire logic [10:0] out_bytes_used
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_value_valid) |->
      (out_value == 32'd0 && out_value_index == 6'd0 && out_block_done))
    else $error("status-only result carries data");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != 3'd0) |->
      (out_block_done && !out_value_valid && out_bytes_used == 11'd0))
    else $error("malformed error result");

  a_used_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_block_done) |-> (out_bytes_used == 11'd0))
    else $error("bytes used shown before block end");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status != 3'd7))
    else $error("unknown status code");

endmodule

bind pfor_block_decoder_top pfor_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_value      (out_value),
  .out_value_index(out_value_index),
  .out_value_valid(out_value_valid),
  .out_block_done (out_block_done),
  .out_status     (out_status),
  .out_bytes_used (out_bytes_used)
);

`default_nettype wire

@@ tb/pfor_block_decoder_top_test.sv @@
`timescale 1ns / 1ps

module pfor_block_decoder_top_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_frame_byte = '0;
  logic        in_frame_end = 1'b0;
  logic [6:0]  in_value_count = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_value;
  logic [5:0]  out_value_index;
  logic        out_value_valid;
  logic        out_block_done;
  logic [2:0]  out_status;
  logic [10:0] out_bytes_used;

  pfor_block_decoder_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_frame_byte(in_frame_byte), .in_frame_end(in_frame_end),
    .in_value_count(in_value_count),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_value(out_value), .out_value_index(out_value_index),
    .out_value_valid(out_value_valid), .out_block_done(out_block_done),
    .out_status(out_status), .out_bytes_used(out_bytes_used)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
    logic [6:0] fcount;
  } frame_item_t;

  // Directed row: an input byte, and optionally a hand-written expectation
  // of a single status result that replaces whatever the decoder model says.
  typedef struct packed {
    frame_item_t       item;
    logic              typed;
    pfor_pkg::status_t st;
    logic [10:0]       used;
  } directed_row_t;

  typedef enum logic [2:0] {
    DP_HEADER, DP_COUNT, DP_POS, DP_VARINT, DP_STREAM, DP_DROP
  } dec_phase_e;

  localparam int MAX_COUNT = 64;

  // Decoder model state.
  dec_phase_e  dp_phase = DP_HEADER;
  int unsigned dp_width = 0;
  int unsigned dp_count = 0;
  int unsigned dp_exc_total = 0;
  int unsigned dp_exc_seen = 0;
  int unsigned dp_pos = 0;
  logic [31:0] dp_high_acc = '0;
  int unsigned dp_high_bytes = 0;
  logic [31:0] dp_high [64];
  logic [63:0] dp_high_set = '0;
  logic [63:0] dp_bits = '0;
  int unsigned dp_nbits = 0;
  int unsigned dp_emitted = 0;
  logic [10:0] dp_bytes = '0;

  pfor_pkg::res_t expected_q[$];
  int   n_predicted = 0;
  int   mismatches = 0;
  bit   pop_steady = 1'b0;
  bit   push_steady = 1'b0;

  function automatic void add_result(logic [31:0] v, int unsigned idx, logic valid,
                                     logic done, pfor_pkg::status_t st,
                                     logic [10:0] used);
    pfor_pkg::res_t r;
    r.value = v;
    r.value_index = idx[5:0];
    r.value_valid = valid;
    r.block_done = done;
    r.status = st;
    r.bytes_used = used;
    expected_q.insert(expected_q.size(), r);
    n_predicted++;
  endfunction

  function automatic void decode_error(pfor_pkg::status_t st);
    dp_phase = DP_DROP;
    add_result('0, 0, 1'b0, 1'b1, st, '0);
  endfunction

  function automatic void emit_value(logic [31:0] low);
    int unsigned idx;
    logic [31:0] v;
    logic        done;
    idx = dp_emitted;
    v = low;
    if (dp_high_set[idx % 64] && dp_width < 32)
      v = v | (dp_high[idx % 64] << dp_width);
    dp_emitted++;
    done = dp_emitted >= dp_count;
    if (done)
      dp_phase = DP_DROP;
    add_result(v, idx, 1'b1, done, pfor_pkg::STAT_OK, done ? dp_bytes : 11'd0);
  endfunction

  function automatic void start_stream();
    dp_phase = DP_STREAM;
    dp_bits = '0;
    dp_nbits = 0;
    dp_emitted = 0;
    if (dp_count == 0) begin
      dp_phase = DP_DROP;
      add_result('0, 0, 1'b0, 1'b1, pfor_pkg::STAT_OK, dp_bytes);
    end else if (dp_width == 0) begin
      while (dp_emitted < dp_count)
        emit_value('0);
    end
  endfunction

  // Advances the decoder model by one accepted byte.
  function automatic void decode_byte(frame_item_t it);
    logic [31:0] low7;
    logic [31:0] limit;
    logic [31:0] wmask;
    int unsigned slot;
    if (dp_phase == DP_HEADER) begin
      dp_bytes = '0;
      dp_emitted = 0;
      dp_exc_seen = 0;
      dp_high_set = '0;
    end
    dp_bytes = dp_bytes + 11'd1;
    case (dp_phase)
      DP_HEADER: begin
        dp_count = it.fcount;
        dp_width = it.fbyte[5:0];
        if (it.fend)
          decode_error(pfor_pkg::STAT_TRUNC);
        else if (dp_count > MAX_COUNT)
          decode_error(pfor_pkg::STAT_BAD_POS);
        else if (it.fbyte > 8'd32)
          decode_error(pfor_pkg::STAT_BAD_WIDTH);
        else
          dp_phase = DP_COUNT;
      end
      DP_COUNT: begin
        dp_exc_total = it.fbyte;
        if (dp_width == 32 && it.fbyte != 0)
          decode_error(pfor_pkg::STAT_W32_EXC);
        else if (it.fbyte == 0)
          start_stream();
        else
          dp_phase = DP_POS;
      end
      DP_POS: begin
        if (it.fbyte >= dp_count) begin
          decode_error(pfor_pkg::STAT_BAD_POS);
        end else begin
          dp_pos = it.fbyte;
          dp_high_acc = '0;
          dp_high_bytes = 0;
          dp_phase = DP_VARINT;
        end
      end
      DP_VARINT: begin
        low7 = {25'd0, it.fbyte[6:0]};
        if (dp_high_bytes == 4 && low7 > 32'h0F) begin
          decode_error(pfor_pkg::STAT_BAD_VINT);
        end else begin
          dp_high_acc = dp_high_acc | (low7 << (7 * dp_high_bytes));
          if (!it.fbyte[7]) begin
            slot = dp_pos % 64;
            limit = (dp_width >= 32) ? 32'd0 : (32'hFFFF_FFFF >> dp_width);
            if (dp_high_acc > limit) begin
              decode_error(pfor_pkg::STAT_HIGH_WIDE);
            end else begin
              dp_high[slot] = dp_high_set[slot] ? (dp_high[slot] | dp_high_acc)
                                                : dp_high_acc;
              dp_high_set[slot] = 1'b1;
              dp_exc_seen++;
              if (dp_exc_seen >= dp_exc_total)
                start_stream();
              else
                dp_phase = DP_POS;
            end
          end else begin
            dp_high_bytes++;
            if (dp_high_bytes >= 5)
              decode_error(pfor_pkg::STAT_BAD_VINT);
          end
        end
      end
      DP_STREAM: begin
        dp_bits = dp_bits | (64'(it.fbyte) << dp_nbits);
        dp_nbits += 8;
        wmask = (dp_width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << dp_width) - 32'd1);
        while (dp_width > 0 && dp_nbits >= dp_width && dp_emitted < dp_count) begin
          emit_value(dp_bits[31:0] & wmask);
          dp_bits = dp_bits >> dp_width;
          dp_nbits -= dp_width;
        end
      end
      default: ;
    endcase
    if (it.fend) begin
      if (dp_phase != DP_DROP)
        decode_error(pfor_pkg::STAT_TRUNC);
      dp_phase = DP_HEADER;
    end
  endfunction

  // Drives one byte from the falling edge and holds it until the transfer.
  // The full flag only moves at a rising edge, so its value at the falling
  // edge is the one the next rising edge sees.
  task automatic send_byte(frame_item_t it);
    logic full_seen;
    @(negedge clk);
    while (!push_steady && $urandom_range(0, 99) < 15) begin
      in_push = 1'b0;
      in_frame_byte = 8'($urandom);
      @(negedge clk);
    end
    in_push = 1'b1;
    in_frame_byte = it.fbyte;
    in_frame_end = it.fend;
    in_value_count = it.fcount;
    forever begin
      full_seen = in_full;
      @(posedge clk);
      if (!full_seen) break;
      @(negedge clk);
    end
    decode_byte(it);
  endtask

  function automatic frame_item_t mk(logic [7:0] b, logic e, logic [6:0] c);
    frame_item_t it;
    it.fbyte = b;
    it.fend = e;
    it.fcount = c;
    return it;
  endfunction

  // Builds one frame: mostly well-formed blocks with random content, some
  // truncated, corrupted or with an oversized value count.
  task automatic random_frame(output int nbytes);
    frame_item_t fr[$];
    int unsigned w, cnt, nexc, p, hi, sbytes, cut;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 4);
    else w = $urandom_range(0, 32);
    if ($urandom_range(0, 9) == 0) cnt = $urandom_range(13, 64);
    else if ($urandom_range(0, 19) == 0) cnt = 64;
    else cnt = $urandom_range(0, 12);
    if ($urandom_range(0, 19) == 0) cnt = $urandom_range(65, 127);
    nexc = (cnt > 0 && cnt <= 64 && w < 32) ? $urandom_range(0, 3) : 0;
    fr.insert(fr.size(), mk(8'(w), 1'b0, 7'(cnt)));
    fr.insert(fr.size(), mk(8'(nexc), 1'b0, 7'($urandom)));
    for (int i = 0; i < nexc; i++) begin
      p = $urandom_range(0, cnt - 1);
      fr.insert(fr.size(), mk(8'(p), 1'b0, 7'($urandom)));
      hi = $urandom & ((w == 0) ? 32'hFFFF_FFFF : (32'hFFFF_FFFF >> w));
      if ($urandom_range(0, 1) == 0) hi = hi & 32'hFF;
      do begin
        b = {1'b0, hi[6:0]};
        hi = hi >> 7;
        if (hi != 0) b[7] = 1'b1;
        fr.insert(fr.size(), mk(b, 1'b0, 7'($urandom)));
      end while (hi != 0);
    end
    sbytes = (cnt * w + 7) / 8;
    for (int i = 0; i < sbytes + $urandom_range(0, 2); i++)
      fr.insert(fr.size(), mk(8'($urandom), 1'b0, 7'($urandom)));
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 0) begin
        cut = $urandom_range(1, fr.size());
        while (fr.size() > cut) void'(fr.pop_back());
      end else begin
        fr[$urandom_range(0, fr.size() - 1)].fbyte = 8'($urandom);
      end
    end
    fr[fr.size() - 1].fend = 1'b1;
    foreach (fr[i]) send_byte(fr[i]);
    nbytes = fr.size();
  endtask

  // Directed frames: the header and exception errors, an empty block,
  // width zero with patched highs, and a stream cut short after two values.
  directed_row_t directed [] = '{
    '{mk(8'd0,   1'b1, 7'd3),   1'b1, pfor_pkg::STAT_TRUNC,     11'd0},
    '{mk(8'd33,  1'b0, 7'd1),   1'b1, pfor_pkg::STAT_BAD_WIDTH, 11'd0},
    '{mk(8'd0,   1'b1, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd255, 1'b0, 7'd127), 1'b1, pfor_pkg::STAT_BAD_POS,   11'd0},
    '{mk(8'd0,   1'b1, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd32,  1'b0, 7'd64),  1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b1, 7'd0),   1'b1, pfor_pkg::STAT_W32_EXC,   11'd0},
    '{mk(8'd5,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd0,   1'b1, 7'd0),   1'b1, pfor_pkg::STAT_OK,        11'd2},
    '{mk(8'd0,   1'b0, 7'd3),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd2,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'h85,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'h01,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hFF,  1'b1, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd4,   1'b0, 7'd2),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hFF,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hFF,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hFF,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hFF,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'h7F,  1'b1, 7'd0),   1'b1, pfor_pkg::STAT_BAD_VINT,  11'd0},
    '{mk(8'd8,   1'b0, 7'd3),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd0,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'hAA,  1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'h55,  1'b1, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd28,  1'b0, 7'd1),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd1,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'd0,   1'b0, 7'd0),   1'b0, pfor_pkg::STAT_OK,        11'd0},
    '{mk(8'h10,  1'b1, 7'd0),   1'b1, pfor_pkg::STAT_HIGH_WIDE, 11'd0}
  };

  // Result side: pop at random except during one steady stretch, and check
  // each transfer against the oldest expectation.
  always @(negedge clk)
    out_pop <= pop_steady || ($urandom_range(0, 99) >= 15);

  always @(posedge clk) begin
    pfor_pkg::res_t got;
    pfor_pkg::res_t want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_value, out_value_index, out_value_valid, out_block_done,
              out_status, out_bytes_used};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    int sent;
    int nb;
    int sz;
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Typed rows replace the model's prediction with the written one.
    foreach (directed[i]) begin
      sz = n_predicted;
      send_byte(directed[i].item);
      if (directed[i].typed) begin
        repeat (n_predicted - sz) void'(expected_q.pop_back());
        add_result('0, 0, 1'b0, 1'b1, directed[i].st, directed[i].used);
      end
    end

    // Hold the input until every outstanding result has drained.
    @(negedge clk);
    in_push = 1'b0;
    wait (expected_q.size() == 0);

    sent = 0;
    while (sent < 90) begin
      push_steady = (sent >= 30 && sent < 60);
      pop_steady = push_steady;
      random_frame(nb);
      sent += nb;
    end
    @(negedge clk);
    in_push = 1'b0;
    push_steady = 1'b0;
    pop_steady = 1'b0;

    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
